// ===== hdl/iqap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqap_pkg
// shared widths, constants, beat types and arctangent table for the
// rectangular-to-polar converter
// ----------------------------------------------------------------------------
package iqap_pkg;

    // sample width handled by the datapath and number of rotation stages
    localparam int SAMPLE_BITS   = 18;
    localparam int CORDIC_STAGES = 16;

    // fixed field widths of the stream beats
    localparam int IN_W    = 18;
    localparam int AMP_W   = 18;
    localparam int PHASE_W = 16;
    localparam int TDATA_W = 40;

    // internal fixed point
    localparam int FRAC_BITS = 16;
    localparam int XY_W      = SAMPLE_BITS + 3 + FRAC_BITS;
    localparam int Z_W       = 26;
    localparam int PH_W      = Z_W - 9;
    localparam int XP_W      = (XY_W > 34) ? XY_W - 1 : 33;
    localparam int HI_W      = XP_W - 32;
    localparam int TOT_W     = XP_W + 32;
    localparam int ATAN_ENTRIES = 30;

    localparam int PHASE_MAX = 23040;
    localparam logic [AMP_W-1:0] AMP_MAX = '1;

    // 180 degrees in the z format
    localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180 * 65536);

    // inverse cordic gain in q32
    localparam logic [63:0] GAIN_FULL =
        64'd2608131496 + (64'd1738754331 >> (2 * CORDIC_STAGES));
    localparam logic [31:0] GAIN = GAIN_FULL[31:0];

    // one vector on its way through the rotation stages
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   axis;
        logic                   last;
    } cordic_t;

    // one finished result
    typedef struct packed {
        logic [AMP_W-1:0]          amp;
        logic signed [PHASE_W-1:0] phase;
        logic                      last;
    } res_t;

    // round(atan(2^-k) * 180 / pi * 65536)
    function automatic logic signed [Z_W-1:0] atan_q16(input int k);
        logic signed [Z_W-1:0] v;
        case (k)
            0:       v = Z_W'(2949120);
            1:       v = Z_W'(1740967);
            2:       v = Z_W'(919879);
            3:       v = Z_W'(466945);
            4:       v = Z_W'(234379);
            5:       v = Z_W'(117304);
            6:       v = Z_W'(58666);
            7:       v = Z_W'(29335);
            8:       v = Z_W'(14668);
            9:       v = Z_W'(7334);
            10:      v = Z_W'(3667);
            11:      v = Z_W'(1833);
            12:      v = Z_W'(917);
            13:      v = Z_W'(458);
            14:      v = Z_W'(229);
            15:      v = Z_W'(115);
            16:      v = Z_W'(57);
            17:      v = Z_W'(29);
            18:      v = Z_W'(14);
            19:      v = Z_W'(7);
            20:      v = Z_W'(4);
            21:      v = Z_W'(2);
            22:      v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/iqap_cordic_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqap_cordic_core
// pre-rotation into the right half plane followed by one register stage
// per vectoring rotation; the whole chain moves when adv is high
// ----------------------------------------------------------------------------
module iqap_cordic_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire logic [iqap_pkg::IN_W-1:0]  in_i,
    input  wire logic [iqap_pkg::IN_W-1:0]  in_q,
    input  wire logic                       in_last,
    output logic                            out_valid,
    output iqap_pkg::cordic_t               out_vec
);

    localparam int SB = iqap_pkg::SAMPLE_BITS;
    localparam int N  = iqap_pkg::CORDIC_STAGES;

    iqap_pkg::cordic_t vec_reg [0:N];
    logic              vld_reg [0:N];

    // pre-rotation
    logic [31:0]                      raw_i;
    logic [31:0]                      raw_q;
    logic signed [SB-1:0]             samp_i;
    logic signed [SB-1:0]             samp_q;
    logic signed [iqap_pkg::XY_W-1:0] ext_i;
    logic signed [iqap_pkg::XY_W-1:0] ext_q;
    logic                             neg;
    iqap_pkg::cordic_t                pre_next;

    always_comb begin
        raw_i  = {{(32 - iqap_pkg::IN_W){1'b0}}, in_i};
        raw_q  = {{(32 - iqap_pkg::IN_W){1'b0}}, in_q};
        samp_i = raw_i[SB-1:0];
        samp_q = raw_q[SB-1:0];
        ext_i  = {{(iqap_pkg::XY_W - SB){samp_i[SB-1]}}, samp_i};
        ext_q  = {{(iqap_pkg::XY_W - SB){samp_q[SB-1]}}, samp_q};
        neg    = samp_i[SB-1];
        pre_next.axis = (samp_q == '0);
        pre_next.last = in_last;
        if (neg) begin
            pre_next.x = (-ext_i) <<< iqap_pkg::FRAC_BITS;
            pre_next.y = (-ext_q) <<< iqap_pkg::FRAC_BITS;
            pre_next.z = samp_q[SB-1] ? -iqap_pkg::Z_HALF_TURN : iqap_pkg::Z_HALF_TURN;
        end else begin
            pre_next.x = ext_i <<< iqap_pkg::FRAC_BITS;
            pre_next.y = ext_q <<< iqap_pkg::FRAC_BITS;
            pre_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vec_reg[0] <= pre_next;
        end
    end

    // rotation stages, vectors on the real axis pass unchanged
    for (genvar k = 0; k < N; k++) begin : g_stage
        iqap_pkg::cordic_t      rot_next;
        logic signed [iqap_pkg::XY_W-1:0] xs;
        logic signed [iqap_pkg::XY_W-1:0] ys;

        always_comb begin
            xs       = vec_reg[k].x >>> k;
            ys       = vec_reg[k].y >>> k;
            rot_next = vec_reg[k];
            if (!vec_reg[k].axis) begin
                if (!vec_reg[k].y[iqap_pkg::XY_W-1]) begin
                    rot_next.x = vec_reg[k].x + ys;
                    rot_next.y = vec_reg[k].y - xs;
                    rot_next.z = vec_reg[k].z + iqap_pkg::atan_q16(k);
                end else begin
                    rot_next.x = vec_reg[k].x - ys;
                    rot_next.y = vec_reg[k].y + xs;
                    rot_next.z = vec_reg[k].z - iqap_pkg::atan_q16(k);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                vec_reg[k+1] <= rot_next;
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_vec   = vec_reg[N];

endmodule
`default_nettype wire

// ===== hdl/iq_to_amplitude_phase.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iq_to_amplitude_phase
// rectangular-to-polar converter: cordic vectoring pipeline with gain
// compensation, amplitude and phase in degrees from one i/q beat
// ----------------------------------------------------------------------------
// One I/Q pair is taken per clock and one result beat leaves per clock at full
// throughput. A pair travels through a pre-rotation register, CORDIC_STAGES
// rotation registers (one add/subtract stage each), a gain multiply register,
// a rounding/saturation register and the output register. The pre-rotation
// register loads at the accepting edge, and the result then passes the rotation,
// gain multiply, rounding/saturation and output registers before it shows on
// m_tvalid. The amplitude is rounded to the input lsb and saturates at the field
// maximum; the phase is degrees times 128, clamped to +-180. A pair on the real
// axis (q = 0) gives |i| and 0 or +180 degrees. The output register is backed
// by a one-beat skid register, and s_tready is low only while that skid
// register is full; then the whole pipeline holds.
// ----------------------------------------------------------------------------
module iq_to_amplitude_phase (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: i_sample [17:0], q_sample [35:18], zero [39:36]
    input  wire logic [iqap_pkg::TDATA_W-1:0]  s_tdata,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tlast,
    output logic                               s_tready,
    // m_tdata: amplitude [17:0], phase_deg [33:18], zero [39:34]
    output logic [iqap_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tvalid,
    output logic                               m_tlast,
    input  wire logic                          m_tready
);

    localparam int IW = iqap_pkg::IN_W;
    localparam int XP = iqap_pkg::XP_W;

    // pipeline advance, held while the skid beat waits
    logic adv;

    logic              core_vld;
    iqap_pkg::cordic_t core_vec;

    iqap_cordic_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_i      (s_tdata[IW-1:0]),
        .in_q      (s_tdata[2*IW-1:IW]),
        .in_last   (s_tlast),
        .out_valid (core_vld),
        .out_vec   (core_vec)
    );

    // ------------------------------------------------------------------
    // gain stage: low partial product, real-axis amplitude, phase rounding and clamp
    // ------------------------------------------------------------------
    logic [XP-1:0]                        x_pos;
    logic signed [iqap_pkg::Z_W-1:0]      z_rnd;
    logic signed [iqap_pkg::PH_W-1:0]     ph_wide;
    logic signed [iqap_pkg::PH_W-1:0]     ph_lim;
    logic [63:0]                          axis_wide;

    logic                                 m1_vld_reg;
    logic [63:0]                          m1_plo_reg,   m1_plo_next;
    logic [iqap_pkg::HI_W-1:0]            m1_xhi_reg,   m1_xhi_next;
    logic [iqap_pkg::AMP_W-1:0]           m1_aamp_reg,  m1_aamp_next;
    logic signed [iqap_pkg::PHASE_W-1:0]  m1_phase_reg, m1_phase_next;
    logic                                 m1_axis_reg;
    logic                                 m1_last_reg;

    always_comb begin
        // a negative residual x counts as zero amplitude
        if (core_vec.x[iqap_pkg::XY_W-1]) begin
            x_pos = '0;
        end else begin
            x_pos = XP'(core_vec.x[iqap_pkg::XY_W-2:0]);
        end
        m1_plo_next = 64'(x_pos[31:0]) * 64'(iqap_pkg::GAIN);
        m1_xhi_next = x_pos[XP-1:32];

        // real axis: amplitude is |i| straight from x
        axis_wide = 64'(x_pos[XP-1:iqap_pkg::FRAC_BITS]);
        if (axis_wide > 64'(iqap_pkg::AMP_MAX)) begin
            m1_aamp_next = iqap_pkg::AMP_MAX;
        end else begin
            m1_aamp_next = axis_wide[iqap_pkg::AMP_W-1:0];
        end

        // round to 7 fractional bits, clamp to +-180 degrees
        z_rnd   = core_vec.z + iqap_pkg::Z_W'(256);
        ph_wide = iqap_pkg::PH_W'(z_rnd >>> 9);
        ph_lim  = iqap_pkg::PH_W'(iqap_pkg::PHASE_MAX);
        if (ph_wide > ph_lim) begin
            m1_phase_next = iqap_pkg::PHASE_W'(ph_lim);
        end else if (ph_wide < -ph_lim) begin
            m1_phase_next = iqap_pkg::PHASE_W'(-ph_lim);
        end else begin
            m1_phase_next = ph_wide[iqap_pkg::PHASE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
        end else if (adv) begin
            m1_vld_reg <= core_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_plo_reg   <= m1_plo_next;
            m1_xhi_reg   <= m1_xhi_next;
            m1_aamp_reg  <= m1_aamp_next;
            m1_phase_reg <= m1_phase_next;
            m1_axis_reg  <= core_vec.axis;
            m1_last_reg  <= core_vec.last;
        end
    end

    // ------------------------------------------------------------------
    // rounding stage: high partial product, sum, round and saturate
    // ------------------------------------------------------------------
    logic [iqap_pkg::HI_W+31:0]  p_hi;
    logic [iqap_pkg::TOT_W-1:0]  total;
    logic [63:0]                 amp_wide;

    logic          m2_vld_reg;
    iqap_pkg::res_t m2_res_reg, m2_res_next;

    always_comb begin
        p_hi     = (iqap_pkg::HI_W + 32)'(m1_xhi_reg) * (iqap_pkg::HI_W + 32)'(iqap_pkg::GAIN);
        total    = {p_hi, 32'b0} + iqap_pkg::TOT_W'(m1_plo_reg)
                 + (iqap_pkg::TOT_W'(1) << 47);
        amp_wide = 64'(total[iqap_pkg::TOT_W-1:48]);
        if (m1_axis_reg) begin
            m2_res_next.amp = m1_aamp_reg;
        end else if (amp_wide > 64'(iqap_pkg::AMP_MAX)) begin
            m2_res_next.amp = iqap_pkg::AMP_MAX;
        end else begin
            m2_res_next.amp = amp_wide[iqap_pkg::AMP_W-1:0];
        end
        m2_res_next.phase = m1_phase_reg;
        m2_res_next.last  = m1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_vld_reg <= 1'b0;
        end else if (adv) begin
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_res_reg <= m2_res_next;
        end
    end

    // ------------------------------------------------------------------
    // output register with one-beat skid
    // ------------------------------------------------------------------
    logic           out_vld_reg,  out_vld_next;
    iqap_pkg::res_t out_res_reg,  out_res_next;
    logic           skid_vld_reg, skid_vld_next;
    iqap_pkg::res_t skid_res_reg, skid_res_next;

    assign adv = !skid_vld_reg;

    always_comb begin
        out_vld_next  = out_vld_reg;
        out_res_next  = out_res_reg;
        skid_vld_next = skid_vld_reg;
        skid_res_next = skid_res_reg;
        if (m_tready || !out_vld_reg) begin
            // output slot free: drain the skid beat first
            if (skid_vld_reg) begin
                out_vld_next  = 1'b1;
                out_res_next  = skid_res_reg;
                skid_vld_next = 1'b0;
            end else begin
                out_vld_next = m2_vld_reg;
                out_res_next = m2_res_reg;
            end
        end else if (adv && m2_vld_reg) begin
            // output held: park the beat leaving the pipeline
            skid_vld_next = 1'b1;
            skid_res_next = m2_res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_res_reg.last;
    assign m_tdata  = {{(iqap_pkg::TDATA_W - iqap_pkg::AMP_W - iqap_pkg::PHASE_W){1'b0}},
                       out_res_reg.phase, out_res_reg.amp};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // the skid beat only exists behind a held output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid beat without output beat");

    // a stalled pipeline keeps its last stage
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(m2_vld_reg) && $stable(m2_res_reg))
        else $error("pipeline moved during stall");

    // the skid fills only when the output is held and a beat arrives
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        !skid_vld_reg && (m_tready || !out_vld_reg) |=> !skid_vld_reg)
        else $error("skid filled while output was free");

    // real-axis pairs give exactly 0 or +180 degrees
    a_axis_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m1_vld_reg && m1_axis_reg |->
            (m1_phase_reg == '0) ||
            (m1_phase_reg == iqap_pkg::PHASE_W'(iqap_pkg::PHASE_MAX)))
        else $error("real-axis phase off");

    // phase stays within +-180 degrees
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m2_vld_reg |->
            (m2_res_reg.phase <= $signed(iqap_pkg::PHASE_W'(iqap_pkg::PHASE_MAX))) &&
            (m2_res_reg.phase >= -$signed(iqap_pkg::PHASE_W'(iqap_pkg::PHASE_MAX))))
        else $error("phase out of range");

endmodule
`default_nettype wire

// ===== test/tb_iq_to_amplitude_phase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iq_to_amplitude_phase
// self-checking bench for the i/q to amplitude/phase converter: drives i/q
// beats in waveforms with random source gaps and sink stalls, predicts every
// result in the bench and compares each output beat field by field
// ----------------------------------------------------------------------------
module tb_iq_to_amplitude_phase;
    import iqap_pkg::*;

    localparam int RAND_PAIRS = 700;
    localparam int ATAN_N     = 30;
    localparam int PH_LIMIT   = 23040;
    localparam longint AMP_TOP = (64'd1 << AMP_W) - 1;

    localparam logic signed [IN_W-1:0] I_MIN = {1'b1, {(IN_W-1){1'b0}}};
    localparam logic signed [IN_W-1:0] I_MAX = {1'b0, {(IN_W-1){1'b1}}};

    // one expected output beat
    typedef struct {
        logic [AMP_W-1:0]          amp;
        logic signed [PHASE_W-1:0] phase;
        logic                      last;
    } polar_t;

    // ------------------------------------------------------------------------
    // scoreboard: turns each accepted i/q pair into the expected polar beat
    // and checks output beats against the oldest one in flight
    // ------------------------------------------------------------------------
    class polar_checker;
        polar_t polar_due[$];
        longint atan_deg[ATAN_N];
        int mismatches;
        int pairs_seen;
        int results_seen;

        function new();
            // atan(2^-k) in degrees, 16 fractional bits
            atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                         14668, 7334, 3667, 1833, 917, 458, 229, 115,
                         57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
            mismatches   = 0;
            pairs_seen   = 0;
            results_seen = 0;
        endfunction

        function polar_t to_polar(logic signed [IN_W-1:0] i_s, logic signed [IN_W-1:0] q_s,
                                  logic last_flag);
            polar_t res;
            longint iv, qv, x, y, z, xs, ys, ph;
            logic [63:0] mag, gain;
            logic [127:0] prod;
            iv = i_s;
            qv = q_s;
            gain = 64'd2608131496 + (64'd1738754331 >> (2 * CORDIC_STAGES));
            if (qv == 0) begin
                // real axis: exact magnitude, 0 or +180 degrees
                mag = (iv < 0) ? -iv : iv;
                ph  = (iv < 0) ? PH_LIMIT : 0;
            end else begin
                x = iv;
                y = qv;
                z = 0;
                // left half plane: flip into the right half, start at +-180
                if (x < 0) begin
                    x = -x;
                    y = -y;
                    z = (qv >= 0) ? 180 * 65536 : -180 * 65536;
                end
                x = x * 65536;
                y = y * 65536;
                for (int k = 0; k < CORDIC_STAGES && k < ATAN_N; k++) begin
                    xs = x >>> k;
                    ys = y >>> k;
                    if (y >= 0) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + atan_deg[k];
                    end else begin
                        x = x - ys;
                        y = y + xs;
                        z = z - atan_deg[k];
                    end
                end
                mag  = (x < 0) ? 64'd0 : x;
                prod = (128'(mag) * 128'(gain) + (128'd1 << 47)) >> 48;
                mag  = prod[63:0];
                ph   = (z + 256) >>> 9;
                if (ph > PH_LIMIT)
                    ph = PH_LIMIT;
                if (ph < -PH_LIMIT)
                    ph = -PH_LIMIT;
            end
            if (mag > AMP_TOP)
                mag = AMP_TOP;
            res.amp   = mag[AMP_W-1:0];
            res.phase = ph[PHASE_W-1:0];
            res.last  = last_flag;
            return res;
        endfunction

        function void take_pair(logic signed [IN_W-1:0] i_s, logic signed [IN_W-1:0] q_s,
                                logic last_flag);
            polar_due.push_back(to_polar(i_s, q_s, last_flag));
            pairs_seen++;
        endfunction

        function void check_polar(logic [AMP_W-1:0] amp, logic signed [PHASE_W-1:0] phase,
                                  logic last_flag);
            polar_t exp_beat;
            results_seen++;
            if (polar_due.size() == 0) begin
                $error("output beat with nothing in flight: amplitude %0d phase %0d",
                       amp, phase);
                mismatches++;
                return;
            end
            exp_beat = polar_due.pop_front();
            if (amp !== exp_beat.amp) begin
                $error("amplitude: expected %0d, got %0d", exp_beat.amp, amp);
                mismatches++;
            end
            if (phase !== exp_beat.phase) begin
                $error("phase_deg: expected %0d, got %0d", exp_beat.phase, phase);
                mismatches++;
            end
            if (last_flag !== exp_beat.last) begin
                $error("last_out: expected %0b, got %0b", exp_beat.last, last_flag);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn;
    logic [TDATA_W-1:0] s_tdata;
    logic s_tvalid;
    logic s_tlast;
    logic s_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic m_tvalid;
    logic m_tlast;
    logic m_tready;

    // 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    iq_to_amplitude_phase dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tready (m_tready)
    );

    polar_checker sb = new();

    // beat counters, bumped at the rising edge and watched by the drivers
    // at the falling edge
    int  n_in  = 0;
    int  n_out = 0;
    int  waveforms = 0;
    // per-stretch switches for source gaps and sink stalls
    logic src_idle = 1'b0;
    logic snk_idle = 1'b0;

    // ------------------------------------------------------------------------
    // monitor: both channels sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.take_pair(s_tdata[IN_W-1:0], s_tdata[2*IN_W-1:IN_W], s_tlast);
                n_in++;
            end
            if (m_tvalid && m_tready) begin
                sb.check_polar(m_tdata[AMP_W-1:0], m_tdata[AMP_W+PHASE_W-1:AMP_W], m_tlast);
                n_out++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sink: random stall before each beat while stalls are on
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        int seen;
        m_tready = 1'b0;
        while (!aresetn)
            @(negedge aclk);
        forever begin
            stall = snk_idle ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            seen = n_out;
            // hold ready until one beat has left
            do @(negedge aclk); while (n_out == seen);
        end
    end

    // ------------------------------------------------------------------------
    // source: one i/q beat, optional gap first, valid held until accepted
    // ------------------------------------------------------------------------
    task automatic send_pair(input logic signed [IN_W-1:0] i_s,
                             input logic signed [IN_W-1:0] q_s, input logic last_flag);
        int gap;
        int seen;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {{(TDATA_W-2*IN_W){1'b0}}, q_s, i_s};
        s_tlast  <= last_flag;
        s_tvalid <= 1'b1;
        seen = n_in;
        do @(negedge aclk); while (n_in == seen);
    endtask

    // random pair, mixing full-range values with the awkward regions
    task automatic draw_pair(output logic signed [IN_W-1:0] i_s,
                             output logic signed [IN_W-1:0] q_s);
        int kind;
        kind = $urandom_range(0, 9);
        i_s = IN_W'($urandom);
        q_s = IN_W'($urandom);
        case (kind)
            4: begin
                // tiny vectors where rounding dominates
                i_s = IN_W'(int'($urandom_range(0, 16)) - 8);
                q_s = IN_W'(int'($urandom_range(0, 16)) - 8);
            end
            5: q_s = '0;
            6: i_s = '0;
            7: begin
                // close to the negative real axis, where the angle wraps
                i_s = -IN_W'($urandom_range(1, 131072));
                q_s = IN_W'(int'($urandom_range(0, 8)) - 4);
            end
            8: begin
                i_s = $urandom_range(0, 1) ? I_MIN : I_MAX;
                q_s = $urandom_range(0, 1) ? I_MIN : I_MAX;
                if ($urandom_range(0, 3) == 0)
                    q_s = IN_W'(int'($urandom_range(0, 2)) - 1);
            end
            9: begin
                // near full scale on both axes
                i_s = $urandom_range(0, 1) ? I_MIN + IN_W'($urandom_range(0, 15))
                                           : I_MAX - IN_W'($urandom_range(0, 15));
                q_s = $urandom_range(0, 1) ? I_MIN + IN_W'($urandom_range(0, 15))
                                           : I_MAX - IN_W'($urandom_range(0, 15));
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int len;
        int mode;
        logic signed [IN_W-1:0] i_s;
        logic signed [IN_W-1:0] q_s;
        logic last_flag;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: zero vector, real and imaginary axes, corners, the
        // wrap-around near -180/+180 and both last values
        src_idle = 1'b1;
        snk_idle = 1'b1;
        send_pair('0, '0, 1'b0);
        send_pair(I_MAX, '0, 1'b0);
        send_pair(I_MIN, '0, 1'b1);
        send_pair(-18'sd1, '0, 1'b0);
        send_pair(18'sd1, '0, 1'b0);
        send_pair('0, I_MAX, 1'b0);
        send_pair('0, I_MIN, 1'b1);
        send_pair(I_MAX, I_MAX, 1'b0);
        send_pair(I_MIN, I_MIN, 1'b0);
        send_pair(I_MIN, I_MAX, 1'b0);
        send_pair(I_MAX, I_MIN, 1'b1);
        send_pair(-18'sd1, -18'sd1, 1'b0);
        send_pair(18'sd1, -18'sd1, 1'b0);
        send_pair(-18'sd1, 18'sd1, 1'b0);
        send_pair(I_MIN, -18'sd1, 1'b0);
        send_pair(I_MIN, 18'sd1, 1'b0);
        send_pair(-18'sd100000, -18'sd1, 1'b0);
        send_pair(-18'sd100000, 18'sd1, 1'b0);
        send_pair(-18'sd5, -18'sd1, 1'b0);
        send_pair(18'sd3, 18'sd4, 1'b0);
        send_pair(-18'sd3, -18'sd4, 1'b1);
        send_pair(18'sd1, 18'sd1, 1'b0);
        send_pair(-18'sd1, 18'sd0, 1'b1);
        waveforms = 5;

        // random waveforms, each with its own idling mix so that some
        // stretches run at full rate
        while (n_in < 23 + RAND_PAIRS) begin
            mode = $urandom_range(0, 3);
            src_idle = mode[0];
            snk_idle = mode[1];
            len = $urandom_range(1, 32);
            for (int k = 0; k < len; k++) begin
                draw_pair(i_s, q_s);
                last_flag = (k == len - 1);
                // now and then a stray last inside a waveform
                if ($urandom_range(0, 19) == 0)
                    last_flag = ~last_flag;
                send_pair(i_s, q_s, last_flag);
            end
            waveforms++;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // let the pipeline drain, then some slack for stray beats
        while (sb.polar_due.size() != 0)
            @(negedge aclk);
        snk_idle = 1'b0;
        repeat (2 * (CORDIC_STAGES + 4)) @(negedge aclk);

        $display("converted %0d i/q pairs in about %0d waveforms, %0d output beats checked",
                 sb.pairs_seen, waveforms, sb.results_seen);
        $display("corners, both axes, the +-180 wrap and random idling on both sides covered");
        if (sb.mismatches == 0)
            $display("tb_iq_to_amplitude_phase OK");
        else
            $display("tb_iq_to_amplitude_phase NOT OK");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #400000;
        $display("timeout with %0d beats still in flight", sb.polar_due.size());
        $display("tb_iq_to_amplitude_phase NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/iqap_pkg.sv
hdl/iqap_cordic_core.sv
hdl/iq_to_amplitude_phase.sv
test/tb_iq_to_amplitude_phase.sv
